// ----- rtl/htw_pkg.sv -----
// ----------------------------------------------------------------------------
// htw_pkg
// Shared field widths, operation codes and the command and status bundles
// passed between the timing wheel controller and datapath.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int MODE_W   = 2;
  localparam int ID_W     = 4;
  localparam int PERIOD_W = 16;

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

  typedef struct packed {
    logic tick_start;
    logic add_start;
    logic del;
    logic add_write;
    logic flush;
  } htw_cmd_t;

  typedef struct packed {
    logic id_ok;
    logic div_done;
    logic scan_idle;
  } htw_sts_t;

endpackage

// ----- rtl/hashed_timing_wheel_unit.sv -----
// ----------------------------------------------------------------------------
// hashed_timing_wheel_unit
// Hashed timing wheel of periodic tasks: add, delete and tick operations,
// one expiry transfer per task that fires on a tick.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+---------------------------
//   input   | in_mode, in_task_id, in_period     | start high while busy low
//   result  | out_expired_id, out_last           | out_valid, one cycle each
//
// tick: busy while the one-entry-per-cycle scan of the task table memory
// runs through its single read port, then while the last entry drains
// add: busy for the reciprocal divide by WHEEL_SLOTS and the table write
// delete, no-op and ignored ids: busy stays low
// reset is synchronous; the table needs no clearing pass, valid bits clear
// each expiry leaves when the next one is found, the last one in the first
// cycle after busy falls
// ----------------------------------------------------------------------------
module hashed_timing_wheel_unit #(
  parameter int MAX_TASKS   = 16,
  parameter int WHEEL_SLOTS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [htw_pkg::MODE_W-1:0]   in_mode,
  input  logic [htw_pkg::ID_W-1:0]     in_task_id,
  input  logic [htw_pkg::PERIOD_W-1:0] in_period,
  output logic                         out_valid,
  output logic [htw_pkg::ID_W-1:0]     out_expired_id,
  output logic                         out_last
);

  htw_pkg::htw_cmd_t cmd;
  htw_pkg::htw_sts_t sts;

  htw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_mode),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  htw_dp #(
    .MAX_TASKS   (MAX_TASKS),
    .WHEEL_SLOTS (WHEEL_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_task_id     (in_task_id),
    .in_period      (in_period),
    .out_valid      (out_valid),
    .out_expired_id (out_expired_id),
    .out_last       (out_last)
  );

endmodule

// ----- rtl/htw_div.sv -----
// ----------------------------------------------------------------------------
// htw_div
// Divider by the fixed wheel size: quotient from a rounded-up reciprocal
// product, remainder by multiply back and subtract, each held in a register.
// ----------------------------------------------------------------------------
module htw_div #(
  parameter int DIVISOR = 10,
  parameter int QW      = 13,
  parameter int RW      = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [htw_pkg::PERIOD_W-1:0] dividend,
  output logic                         done,
  output logic [QW-1:0]                quot,
  output logic [RW-1:0]                rem
);

  localparam int     DW    = htw_pkg::PERIOD_W;
  localparam int     SH    = DW + $clog2(DIVISOR);
  localparam int     RCP_W = DW + 2;
  localparam int     PRD_W = DW + RCP_W;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) /
                             longint'(DIVISOR);

  logic [DW-1:0]    dvd_r;
  logic [QW-1:0]    quot_r;
  logic [RW-1:0]    rem_r;
  logic             stg1_r;
  logic             stg2_r;
  logic             done_r;
  logic [PRD_W-1:0] prod;
  logic [DW-1:0]    back;

  // exact over the whole dividend range
  assign prod = PRD_W'(dvd_r) * PRD_W'(RECIP);
  assign back = DW'(quot_r) * DW'(DIVISOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg1_r <= 1'b0;
      stg2_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      stg1_r <= start;
      stg2_r <= stg1_r;
      done_r <= stg2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (stg1_r) begin
      quot_r <= QW'(prod >> SH);
    end
    if (stg2_r) begin
      rem_r <= RW'(dvd_r - back);
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

// ----- rtl/htw_ctrl.sv -----
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer for the timing wheel: decodes operations, waits for the divider
// on add and for the entry scan on tick, then flushes the held expiry.
// ----------------------------------------------------------------------------
module htw_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [htw_pkg::MODE_W-1:0] mode,
  input  htw_pkg::htw_sts_t          sts,
  output logic                       busy,
  output htw_pkg::htw_cmd_t          cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (mode)
            htw_pkg::MODE_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
            htw_pkg::MODE_ADD: begin
              if (sts.id_ok) begin
                cmd.add_start = 1'b1;
                state_nxt     = ST_DIV;
              end
            end
            htw_pkg::MODE_DEL: begin
              cmd.del = sts.id_ok;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.add_write = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_idle) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- rtl/htw_dp.sv -----
// ----------------------------------------------------------------------------
// htw_dp
// Timing wheel datapath: task table memory, valid bits, current slot,
// arming arithmetic, entry scan pipeline and the expiry output stage.
// ----------------------------------------------------------------------------
module htw_dp #(
  parameter int MAX_TASKS   = 16,
  parameter int WHEEL_SLOTS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  htw_pkg::htw_cmd_t            cmd,
  output htw_pkg::htw_sts_t            sts,
  input  logic [htw_pkg::ID_W-1:0]     in_task_id,
  input  logic [htw_pkg::PERIOD_W-1:0] in_period,
  output logic                         out_valid,
  output logic [htw_pkg::ID_W-1:0]     out_expired_id,
  output logic                         out_last
);

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SLOT_W = $clog2(WHEEL_SLOTS);
  localparam int MAXQ   = (2**htw_pkg::PERIOD_W - 2) / WHEEL_SLOTS;
  localparam int RND_W  = (MAXQ > 0) ? $clog2(MAXQ + 1) : 1;
  localparam int ENT_W  = 2 * SLOT_W + 2 * RND_W;

  // table entry: slot, rounds left, period remainder, rounds reload
  logic [ENT_W-1:0]       mem [MAX_TASKS];
  logic [ENT_W-1:0]       rd_data_r;
  logic [MAX_TASKS-1:0]   valid_r;
  logic [SLOT_W-1:0]      cur_r, cur_nxt;
  logic [IDX_W-1:0]       id_r;
  logic [IDX_W-1:0]       scan_idx_r;
  logic                   scan_on_r;
  logic [IDX_W-1:0]       pidx_r;
  logic                   pv_r;
  logic                   pend_v_r;
  logic [IDX_W-1:0]       pend_id_r;
  logic                   out_valid_r;
  logic [htw_pkg::ID_W-1:0] out_id_r;
  logic                   out_last_r;

  logic                   div_done;
  logic [RND_W-1:0]       div_quot;
  logic [SLOT_W-1:0]      div_rem;
  logic [htw_pkg::PERIOD_W-1:0] dividend;
  logic [IDX_W-1:0]       id_idx;

  logic [SLOT_W-1:0]      e_slot;
  logic [RND_W-1:0]       e_rounds;
  logic [SLOT_W-1:0]      e_rem;
  logic [RND_W-1:0]       e_reload;
  logic                   hit;
  logic                   expire;

  logic [SLOT_W-1:0]      arm_rem;
  logic [SLOT_W:0]        arm_sum;
  logic [SLOT_W-1:0]      arm_slot;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ENT_W-1:0]       wr_data;

  assign dividend = (in_period == '0) ? '0 : in_period - 1'b1;
  assign id_idx   = IDX_W'(in_task_id);

  htw_div #(
    .DIVISOR (WHEEL_SLOTS),
    .QW      (RND_W),
    .RW      (SLOT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.add_start),
    .dividend (dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign {e_slot, e_rounds, e_rem, e_reload} = rd_data_r;

  assign hit    = pv_r && valid_r[pidx_r] && (e_slot == cur_r);
  assign expire = hit && (e_rounds == '0);

  // slot = (cur + 1 + (period - 1) mod slots) mod slots
  assign arm_rem  = cmd.add_write ? div_rem : e_rem;
  assign arm_sum  = {1'b0, cur_r} + (SLOT_W+1)'(1) + {1'b0, arm_rem};
  assign arm_slot = (arm_sum >= (SLOT_W+1)'(WHEEL_SLOTS)) ?
                    SLOT_W'(arm_sum - (SLOT_W+1)'(WHEEL_SLOTS)) : SLOT_W'(arm_sum);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pidx_r;
    wr_data = rd_data_r;
    if (cmd.add_write) begin
      wr_en   = 1'b1;
      wr_addr = id_r;
      wr_data = {arm_slot, div_quot, div_rem, div_quot};
    end else if (expire) begin
      wr_en   = 1'b1;
      wr_data = {arm_slot, e_reload, e_rem, e_reload};
    end else if (hit) begin
      wr_en   = 1'b1;
      wr_data = {e_slot, RND_W'(e_rounds - 1'b1), e_rem, e_reload};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[scan_idx_r];
  end

  assign cur_nxt = (cur_r == SLOT_W'(WHEEL_SLOTS - 1)) ? '0 : cur_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cur_r       <= '0;
      scan_idx_r  <= '0;
      scan_on_r   <= 1'b0;
      pv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.add_write) begin
        valid_r[id_r] <= 1'b1;
      end else if (cmd.del) begin
        valid_r[id_idx] <= 1'b0;
      end
      if (cmd.tick_start) begin
        cur_r      <= cur_nxt;
        scan_idx_r <= '0;
        scan_on_r  <= 1'b1;
      end else if (scan_on_r) begin
        scan_idx_r <= scan_idx_r + 1'b1;
        if (scan_idx_r == IDX_W'(MAX_TASKS - 1)) begin
          scan_on_r <= 1'b0;
        end
      end
      pv_r        <= scan_on_r;
      out_valid_r <= 1'b0;
      if (expire) begin
        pend_v_r    <= 1'b1;
        out_valid_r <= pend_v_r;
      end else if (cmd.flush) begin
        pend_v_r    <= 1'b0;
        out_valid_r <= pend_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= scan_idx_r;
    if (cmd.add_start) begin
      id_r <= id_idx;
    end
    if (expire) begin
      pend_id_r  <= pidx_r;
      out_id_r   <= htw_pkg::ID_W'(pend_id_r);
      out_last_r <= 1'b0;
    end else if (cmd.flush) begin
      out_id_r   <= htw_pkg::ID_W'(pend_id_r);
      out_last_r <= 1'b1;
    end
  end

  assign sts.id_ok     = (32'(in_task_id) < MAX_TASKS);
  assign sts.div_done  = div_done;
  assign sts.scan_idle = !scan_on_r && !pv_r;

  assign out_valid      = out_valid_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

  a_add_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_write |-> (!scan_on_r && !pv_r))
    else $error("table write from add during scan");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r < SLOT_W'(WHEEL_SLOTS - 1) || cur_r == SLOT_W'(WHEEL_SLOTS - 1))
    else $error("current slot out of range");

  a_last_ends_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> (!out_valid_r && !pend_v_r))
    else $error("expiry after last of tick");

  a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> !pv_r)
    else $error("flush while an entry is still in process");

endmodule
